// File: rtl/b64d_pkg.sv
// Package for the Base64 stream decoder: job type passed from the front end
// to the byte sequencer, queue sizing and the alphabet lookup function.
// No dependencies.
`default_nettype none

package b64d_pkg;

  // Depth of the job queue between the character front end and the byte back end.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);

  localparam logic [7:0] ChPlus  = 8'h2b;  // '+'
  localparam logic [7:0] ChSlash = 8'h2f;  // '/'
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7a;
  localparam logic [7:0] ChDig0  = 8'h30;
  localparam logic [7:0] ChDig9  = 8'h39;

  // One job holds every result word caused by one input character.
  typedef struct packed {
    logic [2:0][7:0] data;      // data[0] goes out first
    logic [1:0]      last_idx;  // index of the last result of the job
    logic            has_byte;  // zero only for a bare end mark
    logic            msg_end;   // last result closes the message
    logic            stopped;   // decoding was halted in this message
  } b64d_job_t;

  // Returns {invalid, value}. Padding and anything outside the alphabet are invalid.
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [7:0] v;
    logic       bad;
    v   = 8'h00;
    bad = 1'b0;
    if (ch >= ChUpA && ch <= ChUpZ) begin
      v = ch - ChUpA;
    end else if (ch >= ChLoA && ch <= ChLoZ) begin
      v = ch - 8'd71;
    end else if (ch >= ChDig0 && ch <= ChDig9) begin
      v = ch + 8'd4;
    end else if (ch == ChPlus) begin
      v = 8'd62;
    end else if (ch == ChSlash) begin
      v = 8'd63;
    end else begin
      bad = 1'b1;
    end
    return {bad, v[5:0]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/b64d_front.sv
// Character front end of the Base64 decoder: classifies each character,
// keeps the group state and builds one job per character that has results.
// Depends on b64d_pkg.
`default_nettype none

module b64d_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        symbol_i,
  input  wire logic              message_end_i,
  output logic                   push_o,
  output b64d_pkg::b64d_job_t    job_o,
  input  wire logic              queue_ready_i
);

  logic [1:0]  fill_q, fill_d;
  logic [17:0] buf_q, buf_d;
  logic        halted_q, halted_d;
  logic        accept;
  logic [6:0]  sx;
  logic [23:0] word;
  logic        group_done;

  assign in_ready_o = queue_ready_i;
  assign accept     = in_valid_i && queue_ready_i;
  assign sx         = b64d_pkg::sextet_of(symbol_i);
  assign word       = {buf_q, sx[5:0]};

  always_comb begin
    fill_d     = fill_q;
    buf_d      = buf_q;
    halted_d   = halted_q;
    group_done = 1'b0;
    job_o      = '0;

    if (!halted_q) begin
      if (sx[6]) begin
        halted_d = 1'b1;
      end else if (fill_q == 2'd3) begin
        group_done    = 1'b1;
        job_o.data[0] = word[23:16];
        job_o.data[1] = word[15:8];
        job_o.data[2] = word[7:0];
        job_o.last_idx = 2'd2;
        job_o.has_byte = 1'b1;
        fill_d = 2'd0;
        buf_d  = '0;
      end else begin
        buf_d  = {buf_q[11:0], sx[5:0]};
        fill_d = fill_q + 2'd1;
      end
    end

    if (message_end_i) begin
      // A completed group leaves fill at zero, so the flush only sees partial groups.
      unique case (fill_d)
        2'd2: begin
          job_o.data[0]  = buf_d[11:4];
          job_o.last_idx = 2'd0;
          job_o.has_byte = 1'b1;
        end
        2'd3: begin
          job_o.data[0]  = buf_d[17:10];
          job_o.data[1]  = buf_d[9:2];
          job_o.last_idx = 2'd1;
          job_o.has_byte = 1'b1;
        end
        default: begin
        end
      endcase
      job_o.msg_end = 1'b1;
      job_o.stopped = halted_d;
      fill_d   = 2'd0;
      buf_d    = '0;
      halted_d = 1'b0;
    end
  end

  assign push_o = accept && (group_done || message_end_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= 2'd0;
      buf_q    <= '0;
      halted_q <= 1'b0;
    end else if (accept) begin
      fill_q   <= fill_d;
      buf_q    <= buf_d;
      halted_q <= halted_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/b64d_fifo.sv
// Job queue of the Base64 decoder: a small register-based FIFO that decouples
// the character front end from the byte back end. Depends on b64d_pkg.
`default_nettype none

module b64d_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  b64d_pkg::b64d_job_t    push_data_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output b64d_pkg::b64d_job_t    pop_data_o,
  input  wire logic              pop_i
);

  b64d_pkg::b64d_job_t mem_q [b64d_pkg::FifoDepth];
  logic [b64d_pkg::FifoAw-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [b64d_pkg::FifoCw-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign ready_o    = (count_q != b64d_pkg::FifoCw'(b64d_pkg::FifoDepth));
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o) else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("job popped from an empty queue");

  a_count_tracks_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != b64d_pkg::FifoCw'(b64d_pkg::FifoDepth)) |->
      (b64d_pkg::FifoAw'(wr_ptr_q - rd_ptr_q) == b64d_pkg::FifoAw'(count_q)))
    else $error("queue fill count disagrees with pointers");

endmodule

`default_nettype wire

// File: rtl/b64d_back.sv
// Byte back end of the Base64 decoder: takes jobs from the queue and sends
// their result words out from a held job register, one per cycle while
// out_ready_i is high. Depends on b64d_pkg.
`default_nettype none

module b64d_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              job_valid_i,
  input  b64d_pkg::b64d_job_t    job_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             data_byte_o,
  output logic                   byte_valid_o,
  output logic                   run_last_o,
  output logic                   output_end_o,
  output logic                   stopped_early_o
);

  b64d_pkg::b64d_job_t cur_q;
  logic                cur_valid_q, cur_valid_d;
  logic [1:0]          idx_q, idx_d;
  logic                is_last;
  logic                take;

  assign is_last = (idx_q == cur_q.last_idx);
  assign take    = cur_valid_q && out_ready_i;
  assign pop_o   = job_valid_i && (!cur_valid_q || (take && is_last));

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (pop_o) begin
      cur_valid_d = 1'b1;
      idx_d       = 2'd0;
    end else if (take) begin
      if (is_last) begin
        cur_valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
    end
  end

  assign out_valid_o     = cur_valid_q;
  assign data_byte_o     = cur_q.data[idx_q];
  assign byte_valid_o    = cur_q.has_byte;
  assign run_last_o      = is_last;
  assign output_end_o    = is_last && cur_q.msg_end;
  assign stopped_early_o = is_last && cur_q.stopped;

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (idx_q <= cur_q.last_idx)) else $error("result index past job end");

  a_bare_mark_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && !cur_q.has_byte) |-> (cur_q.msg_end && cur_q.last_idx == 2'd0))
    else $error("bare end mark job malformed");

  a_stop_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && cur_q.stopped) |-> cur_q.msg_end)
    else $error("stop flag on a job that does not end the message");

  a_advance_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !is_last) |=> (cur_valid_q && idx_q == $past(idx_q) + 2'd1))
    else $error("result index did not advance by one");

endmodule

`default_nettype wire

// File: rtl/base64_stream_decoder_unit.sv
// Top level of the streaming Base64 decoder (standard alphabet).
// Instantiates b64d_front, b64d_fifo and b64d_back; depends on b64d_pkg.
`default_nettype none

// The decoder takes one ASCII character word per cycle on the input channel
// while in_ready_o is high and sends decoded bytes, one word per cycle while
// out_ready_i is high, on the output channel. Every fourth alphabet
// character completes a group and releases three bytes; the first '=' or
// character outside the alphabet (including any code above 127) stops
// decoding until the word flagged with message_end_i, which flushes a
// partial group of two or three values as one or two bytes and clears the
// state. The last result of each message has output_end_o set and reports in
// stopped_early_o whether decoding was halted; if no byte is due at that point
// a single word with byte_valid_o low carries the end mark. run_last_o marks
// the last result caused by one input character. A character's job goes
// through the job queue and the back end's job register before its results
// appear. The front end accepts a character every cycle while the four-entry
// job queue has room; the back end delivers one result word per cycle while
// out_ready_i is high, and a message end may add up to two more words. Both
// channels use valid/ready and the output is driven from registers.
module base64_stream_decoder_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] symbol_i,
  input  wire logic       message_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      data_byte_o,
  output logic            byte_valid_o,
  output logic            run_last_o,
  output logic            output_end_o,
  output logic            stopped_early_o
);

  // Jobs written by the front end: one per character that has any result.
  logic                push;
  b64d_pkg::b64d_job_t push_job;
  logic                queue_ready;

  // Jobs read by the back end.
  logic                job_valid;
  b64d_pkg::b64d_job_t pop_job;
  logic                pop;

  b64d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .symbol_i      (symbol_i),
    .message_end_i (message_end_i),
    .push_o        (push),
    .job_o         (push_job),
    .queue_ready_i (queue_ready)
  );

  b64d_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .ready_o     (queue_ready),
    .valid_o     (job_valid),
    .pop_data_o  (pop_job),
    .pop_i       (pop)
  );

  b64d_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (pop_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .data_byte_o     (data_byte_o),
    .byte_valid_o    (byte_valid_o),
    .run_last_o      (run_last_o),
    .output_end_o    (output_end_o),
    .stopped_early_o (stopped_early_o)
  );

endmodule

`default_nettype wire
